>>> rtl/r2h_pkg.sv
// shared widths and the per-stage data record of the rgb to hsv pipeline
// used by the interfaces, the front stage, the divider cells and the top level
package r2h_pkg;

    localparam int CH_W    = 8;           // one color channel
    localparam int HUE_W   = 16;          // hue in 1/65536 turn
    localparam int HDIV_W  = 11;          // 6*delta, at most 1530
    localparam int SNUM_W  = 16;          // 255*delta
    localparam int N_CELLS = HUE_W;       // one quotient bit per cell

    typedef struct packed {
        logic [HDIV_W-1:0] hue_rem;       // partial remainder, below hue_div
        logic [HDIV_W-1:0] hue_div;       // 6*delta, or 1 for a grey pixel
        logic [HUE_W-1:0]  hue_quo;       // quotient bits shifted in at the lsb
        logic [CH_W-1:0]   sat_rem;       // partial remainder, below sat_div
        logic [CH_W-1:0]   sat_div;       // max, or 1 for a black pixel
        logic [SNUM_W-1:0] sat_word;      // dividend out at the msb, quotient in at the lsb
        logic [CH_W-1:0]   brightness;
    } t_cell_data;

endpackage

>>> rtl/r2h_if.sv
// valid/ready channels of the rgb to hsv block: pixel in, hsv result out
// depends on r2h_pkg for the field widths
interface r2h_pix_if;
    logic                     valid;
    logic                     ready;
    logic [r2h_pkg::CH_W-1:0] red;
    logic [r2h_pkg::CH_W-1:0] green;
    logic [r2h_pkg::CH_W-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface r2h_hsv_if;
    logic                      valid;
    logic                      ready;
    logic [r2h_pkg::HUE_W-1:0] hue_turn;
    logic [r2h_pkg::CH_W-1:0]  saturation;
    logic [r2h_pkg::CH_W-1:0]  brightness;

    modport source (output valid, output hue_turn, output saturation, output brightness,
                    input ready);
    modport sink   (input valid, input hue_turn, input saturation, input brightness,
                    output ready);
endinterface

>>> rtl/r2h_front.sv
// front stage: max, min, delta, hue sector numerator and divisors of one pixel
// depends on r2h_pkg and r2h_pix_if; feeds the first divider cell
module r2h_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    r2h_pix_if.sink             i_pix,
    output logic                o_valid,
    output r2h_pkg::t_cell_data o_data,
    input  logic                i_ready
);

    localparam int CH_W   = r2h_pkg::CH_W;
    localparam int HDIV_W = r2h_pkg::HDIV_W;
    localparam int PAD_W  = HDIV_W - CH_W;

    logic                r_valid;
    r2h_pkg::t_cell_data r_data;
    r2h_pkg::t_cell_data n_data;

    logic [CH_W-1:0]   mx;
    logic [CH_W-1:0]   mn;
    logic [CH_W-1:0]   delta;
    logic [HDIV_W-1:0] d_ext;
    logic [HDIV_W-1:0] r_ext;
    logic [HDIV_W-1:0] g_ext;
    logic [HDIV_W-1:0] b_ext;
    logic [HDIV_W-1:0] d6;
    logic [HDIV_W-1:0] num;

    assign i_pix.ready = !r_valid || i_ready;

    always_comb begin
        mx = i_pix.red;
        if (i_pix.green > mx) mx = i_pix.green;
        if (i_pix.blue > mx)  mx = i_pix.blue;
        mn = i_pix.red;
        if (i_pix.green < mn) mn = i_pix.green;
        if (i_pix.blue < mn)  mn = i_pix.blue;
        delta = mx - mn;

        d_ext = {{PAD_W{1'b0}}, delta};
        r_ext = {{PAD_W{1'b0}}, i_pix.red};
        g_ext = {{PAD_W{1'b0}}, i_pix.green};
        b_ext = {{PAD_W{1'b0}}, i_pix.blue};
        d6    = (d_ext << 2) + (d_ext << 1);

        // sector numerator, in [0, 6*delta) when delta is nonzero, else zero; ties go red, then green
        if (i_pix.red == mx) begin
            if (i_pix.green >= i_pix.blue) begin
                num = g_ext - b_ext;
            end else begin
                num = d6 - (b_ext - g_ext);
            end
        end else if (i_pix.green == mx) begin
            num = (d_ext << 1) + b_ext - r_ext;
        end else begin
            num = (d_ext << 2) + r_ext - g_ext;
        end

        n_data.hue_rem    = num;
        // a divisor of one with a zero dividend gives a zero quotient
        n_data.hue_div    = (delta == '0) ? HDIV_W'(1) : d6;
        n_data.hue_quo    = '0;
        n_data.sat_rem    = '0;
        n_data.sat_div    = (mx == '0) ? CH_W'(1) : mx;
        n_data.sat_word   = {delta, {CH_W{1'b0}}} - {{CH_W{1'b0}}, delta};
        n_data.brightness = mx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_pix.ready) begin
            r_valid <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pix.ready && i_pix.valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> rtl/r2h_cell.sv
// one divider cell: a restoring step for hue and one for saturation
// depends on r2h_pkg; cells are chained by the top level
module r2h_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  r2h_pkg::t_cell_data i_data,
    output logic                o_ready,
    output logic                o_valid,
    output r2h_pkg::t_cell_data o_data,
    input  logic                i_ready
);

    localparam int CH_W   = r2h_pkg::CH_W;
    localparam int HDIV_W = r2h_pkg::HDIV_W;
    localparam int HUE_W  = r2h_pkg::HUE_W;
    localparam int SNUM_W = r2h_pkg::SNUM_W;

    logic                r_valid;
    r2h_pkg::t_cell_data r_data;
    r2h_pkg::t_cell_data n_data;

    logic [HDIV_W:0] hue_try;
    logic [HDIV_W:0] hue_sub;
    logic [CH_W:0]   sat_try;
    logic [CH_W:0]   sat_sub;
    logic            hue_bit;
    logic            sat_bit;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        hue_try = {i_data.hue_rem, 1'b0};
        hue_sub = hue_try - {1'b0, i_data.hue_div};
        hue_bit = (hue_try >= {1'b0, i_data.hue_div});

        sat_try = {i_data.sat_rem, i_data.sat_word[SNUM_W-1]};
        sat_sub = sat_try - {1'b0, i_data.sat_div};
        sat_bit = (sat_try >= {1'b0, i_data.sat_div});

        n_data          = i_data;
        n_data.hue_rem  = hue_bit ? hue_sub[HDIV_W-1:0] : hue_try[HDIV_W-1:0];
        n_data.hue_quo  = {i_data.hue_quo[HUE_W-2:0], hue_bit};
        n_data.sat_rem  = sat_bit ? sat_sub[CH_W-1:0] : sat_try[CH_W-1:0];
        n_data.sat_word = {i_data.sat_word[SNUM_W-2:0], sat_bit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> rtl/rgb_to_hsv_convert_unit.sv
// RGB to HSV converter: takes one pixel per clock unless the output stalls and returns
// hue (1/65536 turn), saturation and brightness, registered in every stage. A front
// stage finds max, min and the hue sector, then a row of sixteen divider cells each
// settles one quotient bit of both the hue and the saturation division. Every stage
// holds one pixel and has its own ready, so the row keeps one pixel per clock and
// fills its bubbles while the output is stalled; the last cell is the output register.
// depends on r2h_pkg, r2h_if, r2h_front and r2h_cell
module rgb_to_hsv_convert_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    r2h_pix_if.sink    i_pix,
    r2h_hsv_if.source  o_hsv
);

    localparam int N_CELLS = r2h_pkg::N_CELLS;
    localparam int CH_W    = r2h_pkg::CH_W;

    logic                stg_valid [N_CELLS+1];
    logic                stg_ready [N_CELLS+1];
    r2h_pkg::t_cell_data stg_data  [N_CELLS+1];

    r2h_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (i_pix),
        .o_valid (stg_valid[0]),
        .o_data  (stg_data[0]),
        .i_ready (stg_ready[0])
    );

    for (genvar k = 0; k < N_CELLS; k++) begin : g_cell
        r2h_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (stg_valid[k]),
            .i_data  (stg_data[k]),
            .o_ready (stg_ready[k]),
            .o_valid (stg_valid[k+1]),
            .o_data  (stg_data[k+1]),
            .i_ready (stg_ready[k+1])
        );
    end

    assign stg_ready[N_CELLS] = o_hsv.ready;

    assign o_hsv.valid      = stg_valid[N_CELLS];
    assign o_hsv.hue_turn   = stg_data[N_CELLS].hue_quo;
    // saturation never exceeds 255, so the upper quotient bits are zero
    assign o_hsv.saturation = stg_data[N_CELLS].sat_word[CH_W-1:0];
    assign o_hsv.brightness = stg_data[N_CELLS].brightness;

endmodule

>>> rtl/r2h_checker.sv
// port-level checks of the rgb to hsv converter, attached by bind
// depends on r2h_pkg for widths; sees only the top level ports
module r2h_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic [r2h_pkg::HUE_W-1:0] i_hue_turn,
    input logic [r2h_pkg::CH_W-1:0]  i_saturation,
    input logic [r2h_pkg::CH_W-1:0]  i_brightness
);

    // nothing leaves the row right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result beat valid right after reset");

    // a stalled result beat holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_hue_turn) && $stable(i_saturation)
            && $stable(i_brightness))
        else $error("stalled result beat changed");

    // black pixel has no hue and no saturation
    a_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_brightness == '0) |-> (i_saturation == '0) && (i_hue_turn == '0))
        else $error("black pixel with hue or saturation");

    // zero saturation only for grey, which has zero hue
    a_grey: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_saturation == '0) |-> (i_hue_turn == '0))
        else $error("grey pixel with nonzero hue");

endmodule

bind rgb_to_hsv_convert_unit r2h_checker u_r2h_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_hsv.valid),
    .i_out_ready  (o_hsv.ready),
    .i_hue_turn   (o_hsv.hue_turn),
    .i_saturation (o_hsv.saturation),
    .i_brightness (o_hsv.brightness)
);

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// self-checking bench for rgb_to_hsv_convert_unit: drives pixels, predicts hue,
// saturation and brightness in integer math and checks every result beat in order
// depends on r2h_pkg and the r2h_pix_if / r2h_hsv_if channel interfaces
module tb_top;

    localparam int CH_W         = r2h_pkg::CH_W;
    localparam int HUE_W        = r2h_pkg::HUE_W;
    localparam int PIPE_LATENCY = 17;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_PRINTED  = 40;

    typedef struct packed {
        logic [HUE_W-1:0] hue_turn;
        logic [CH_W-1:0]  saturation;
        logic [CH_W-1:0]  brightness;
    } t_hsv_result;

    logic i_clk;
    logic i_rst_n;

    r2h_pix_if pix_if ();
    r2h_hsv_if hsv_if ();

    rgb_to_hsv_convert_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if),
        .o_hsv   (hsv_if)
    );

    t_hsv_result hsv_expected[$];
    int          send_idle_pct;
    int          recv_idle_pct;
    int          stall_cycles;
    int          pixels_sent;
    int          results_checked;
    int          mismatch_count;
    int          cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // integer form of the hsv conversion, hue as floor(65536*n / (6*delta))
    function automatic t_hsv_result predict_hsv(input int unsigned r,
                                                input int unsigned g,
                                                input int unsigned b);
        int unsigned mx;
        int unsigned mn;
        int unsigned delta;
        int unsigned n;
        int unsigned q;
        int unsigned sat;
        t_hsv_result res;
        mx = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        mn = r;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        delta = mx - mn;
        sat   = (mx != 0) ? (255 * delta) / mx : 0;
        if (delta == 0) begin
            q = 0;
        end else begin
            // ties resolve red first, then green
            if (r == mx) begin
                n = (g >= b) ? (g - b) : (6 * delta - (b - g));
            end else if (g == mx) begin
                n = 2 * delta + b - r;
            end else begin
                n = 4 * delta + r - g;
            end
            q = (n * 65536) / (6 * delta);
            if (q > 65535) q = 65535;
        end
        res.hue_turn   = q[HUE_W-1:0];
        res.saturation = sat[CH_W-1:0];
        res.brightness = mx[CH_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("[%0t] result %0d: %s got %0d, want %0d",
                     $realtime, results_checked, field, got, want);
    endtask

    // one pixel beat; valid stays high afterwards until the next call or idle_sender
    task automatic send_pixel(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                              input logic [CH_W-1:0] b);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            pix_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.red   <= r;
        pix_if.green <= g;
        pix_if.blue  <= b;
        @(posedge i_clk);
        while (!pix_if.ready) @(posedge i_clk);
        hsv_expected = {hsv_expected, predict_hsv(32'(r), 32'(g), 32'(b))};
        pixels_sent++;
    endtask

    task automatic idle_sender();
        @(negedge i_clk);
        pix_if.valid <= 1'b0;
    endtask

    task automatic drain_results();
        idle_sender();
        while (hsv_expected.size() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY + 3) @(posedge i_clk);
    endtask

    task automatic test_directed_pixels();
        send_pixel(8'd0,   8'd0,   8'd0);     // black
        send_pixel(8'd255, 8'd255, 8'd255);   // white
        send_pixel(8'd128, 8'd128, 8'd128);   // grey
        send_pixel(8'd1,   8'd1,   8'd1);
        send_pixel(8'd255, 8'd0,   8'd0);
        send_pixel(8'd0,   8'd255, 8'd0);
        send_pixel(8'd0,   8'd0,   8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);     // red and green tie
        send_pixel(8'd0,   8'd255, 8'd255);   // green and blue tie
        send_pixel(8'd255, 8'd0,   8'd255);   // red and blue tie
        send_pixel(8'd255, 8'd0,   8'd1);     // red max, wraps just below one turn
        send_pixel(8'd255, 8'd1,   8'd0);
        send_pixel(8'd200, 8'd10,  8'd150);
        send_pixel(8'd10,  8'd200, 8'd150);
        send_pixel(8'd150, 8'd200, 8'd10);
        send_pixel(8'd10,  8'd150, 8'd200);
        send_pixel(8'd150, 8'd10,  8'd200);
        send_pixel(8'd1,   8'd0,   8'd0);
        send_pixel(8'd0,   8'd1,   8'd0);
        send_pixel(8'd0,   8'd0,   8'd1);
        send_pixel(8'd255, 8'd254, 8'd254);
        send_pixel(8'd254, 8'd255, 8'd253);
        send_pixel(8'd170, 8'd85,  8'd255);
    endtask

    task automatic test_random_pixels(input int count);
        logic [CH_W-1:0] r;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] b;
        int              mode;
        for (int i = 0; i < count; i++) begin
            mode = $urandom_range(9);
            r = CH_W'($urandom_range(255));
            g = CH_W'($urandom_range(255));
            b = CH_W'($urandom_range(255));
            case (mode)
                0: begin
                    g = r;
                    b = r;
                end
                1: begin
                    // two channels tie, for the maximum when the third is not larger
                    case ($urandom_range(2))
                        0: r = g;
                        1: b = g;
                        default: b = r;
                    endcase
                end
                2: begin
                    r = $urandom_range(1) ? 8'd255 : {7'd0, 1'($urandom_range(1))};
                    g = $urandom_range(1) ? 8'd255 : {7'd0, 1'($urandom_range(1))};
                    b = $urandom_range(1) ? 8'd255 : {7'd0, 1'($urandom_range(1))};
                end
                3: begin
                    r = CH_W'($urandom_range(3));
                    g = CH_W'($urandom_range(3));
                    b = CH_W'($urandom_range(3));
                end
                default: ;
            endcase
            send_pixel(r, g, b);
        end
    endtask

    // output held off long enough for the pipeline to fill and stall its input
    task automatic test_output_stall();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_cycles  = 250;
        test_random_pixels(80);
    endtask

    // checker: in-order compare of each result beat
    always @(posedge i_clk) begin
        t_hsv_result want;
        if (i_rst_n && hsv_if.valid && hsv_if.ready) begin
            if (hsv_expected.size() == 0) begin
                report_mismatch("unexpected beat, hue_turn", int'(hsv_if.hue_turn), 0);
            end else begin
                want = hsv_expected.pop_front();
                if (hsv_if.hue_turn !== want.hue_turn)
                    report_mismatch("hue_turn", int'(hsv_if.hue_turn),
                                    int'(want.hue_turn));
                if (hsv_if.saturation !== want.saturation)
                    report_mismatch("saturation", int'(hsv_if.saturation),
                                    int'(want.saturation));
                if (hsv_if.brightness !== want.brightness)
                    report_mismatch("brightness", int'(hsv_if.brightness),
                                    int'(want.brightness));
            end
            results_checked++;
        end
    end

    // receiver: random holds, or a counted long stall when requested
    always @(negedge i_clk) begin
        if (stall_cycles > 0) begin
            hsv_if.ready <= 1'b0;
            stall_cycles = stall_cycles - 1;
        end else begin
            hsv_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, hsv_expected.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        pix_if.valid    = 1'b0;
        pix_if.red      = '0;
        pix_if.green    = '0;
        pix_if.blue     = '0;
        hsv_if.ready    = 1'b0;
        send_idle_pct   = 24;
        recv_idle_pct   = 63;
        stall_cycles    = 0;
        pixels_sent     = 0;
        results_checked = 0;
        mismatch_count  = 0;
        cycle_count     = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        test_directed_pixels();
        test_random_pixels(480);
        // sender waits here until every result is back
        drain_results();

        send_idle_pct = 63;
        recv_idle_pct = 24;
        test_random_pixels(500);
        drain_results();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_pixels(500);
        drain_results();

        test_output_stall();
        drain_results();
        repeat (PIPE_LATENCY * 2) @(posedge i_clk);

        $display("covered %0d pixels: directed extremes, greys and ties, three idle mixes,",
                 pixels_sent);
        $display("a 250-cycle output stall and drained pauses; %0d results, %0d mismatches",
                 results_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
